### src/tre_pkg.sv
package tre_pkg;

   // Machine sizes
   localparam int REG_COUNT = 128;
   localparam int MEM_WORDS = 2048;
   localparam int PC_BITS   = 16;

   localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   // Opcodes; codes 12 to 15 are unused and do nothing
   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_ADDI    = 4'd1,
      OP_ADDU    = 4'd2,
      OP_SUB     = 4'd3,
      OP_SUBU    = 4'd4,
      OP_LW      = 4'd5,
      OP_SW      = 4'd6,
      OP_BEQ     = 4'd7,
      OP_J       = 4'd8,
      OP_JR      = 4'd9,
      OP_SLT     = 4'd10,
      OP_PRELOAD = 4'd11
   } op_type;

   // Classified instruction as it travels from front to back
   typedef struct packed {
      op_type      op;
      logic [6:0]  a;
      logic        a_ok;     // A names an existing register
      logic [6:0]  b;
      logic        b_ok;
      logic [6:0]  r2;       // second read port: A for SW/BEQ, else low bits of C
      logic        r2_ok;
      logic [10:0] c;
      logic        c_ok;     // C names an existing memory word
      logic        alu_reg;  // second ALU operand comes from the register file
      logic        alu_sub;  // subtract rather than add
      logic [31:0] pre;
   } itm_type;

endpackage

### src/tre_front.sv
module tre_front (
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [3:0]       in_type,
   input  logic [6:0]       in_a,
   input  logic [6:0]       in_b,
   input  logic [10:0]      in_c,
   input  logic [31:0]      in_pre,
   input  logic             hold,
   output logic             out_valid,
   input  logic             out_ready,
   output tre_pkg::itm_type out_itm
);
   import tre_pkg::*;

   op_type     op;
   logic [6:0] r2;

   // Handshake: nothing enters while held off
   assign out_valid = in_valid && !hold;
   assign in_ready  = out_ready && !hold;

   // Classify the instruction
   assign op = op_type'(in_type);
   assign r2 = (op inside {OP_SW, OP_BEQ}) ? in_a : in_c[6:0];

   assign out_itm.op      = op;
   assign out_itm.a       = in_a;
   assign out_itm.a_ok    = {1'b0, in_a} < 8'(REG_COUNT);
   assign out_itm.b       = in_b;
   assign out_itm.b_ok    = {1'b0, in_b} < 8'(REG_COUNT);
   assign out_itm.r2      = r2;
   assign out_itm.r2_ok   = {1'b0, r2} < 8'(REG_COUNT);
   assign out_itm.c       = in_c;
   assign out_itm.c_ok    = {1'b0, in_c} < 12'(MEM_WORDS);
   assign out_itm.alu_reg = op inside {OP_ADD, OP_SUB};
   // a negative ADDI immediate is a subtract of its magnitude
   assign out_itm.alu_sub = (op inside {OP_SUB, OP_SUBU}) || (op == OP_ADDI && in_c[10]);
   assign out_itm.pre     = in_pre;

endmodule

### src/tre_queue.sv
module tre_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tre_pkg::itm_type in_itm,
   output logic             out_valid,
   input  logic             out_ready,
   output tre_pkg::itm_type out_itm
);
   import tre_pkg::*;

   itm_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_itm   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Item storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_itm;
      end
   end

endmodule

### src/tre_back.sv
module tre_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  tre_pkg::itm_type q_itm,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [15:0]      rsp_next_pc,
   output logic             rsp_reg_written,
   output logic [6:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic             rsp_mem_written,
   output logic [10:0]      rsp_mem_address,
   output logic [31:0]      rsp_mem_value
);
   import tre_pkg::*;

   // State
   logic [31:0]        rf_mem [REG_COUNT];
   logic               rf_vld_ff [REG_COUNT];
   logic [31:0]        dm_mem [MEM_WORDS];
   logic [PC_BITS-1:0] pc_ff;
   logic [PC_BITS-1:0] pc_in;
   logic               clr_ff;
   logic [MEM_AW-1:0]  clr_idx_ff;

   // Execute stage
   logic        x_valid_ff;
   itm_type     x_itm_ff;
   logic [31:0] rd1_ff, rd2_ff, dmr_ff;
   logic [31:0] alt1_ff, alt2_ff, dalt_ff;
   logic        ram1_ff, ram2_ff, dram_ff;
   logic [31:0] alt1_in, alt2_in, dalt_in;
   logic        ram1_in, ram2_in, dram_in;

   // Result register
   logic        rsp_valid_ff;
   logic [15:0] next_pc_ff;
   logic        reg_written_ff;
   logic [6:0]  reg_index_ff;
   logic [31:0] reg_value_ff;
   logic        mem_written_ff;
   logic [10:0] mem_address_ff;
   logic [31:0] mem_value_ff;

   logic               x_adv;
   logic               issue;
   logic [31:0]        vb, v2, dmv, k, alu, rval, mval;
   logic               do_reg, do_mem;
   logic [31:0]        pc_sum;
   logic               rf_we, dm_we;
   logic [MEM_AW-1:0]  dm_waddr;
   logic [31:0]        dm_wdata;

   // Flow control
   assign x_adv    = x_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue    = q_valid && !clr_ff && (!x_valid_ff || x_adv);
   assign q_ready  = issue;
   assign clearing = clr_ff;

   // Operand selection: RAM data, bypassed write data or zero
   assign vb  = ram1_ff ? rd1_ff : alt1_ff;
   assign v2  = ram2_ff ? rd2_ff : alt2_ff;
   assign dmv = dram_ff ? dmr_ff : dalt_ff;

   // Execute
   always_comb begin
      k      = x_itm_ff.alu_reg ? v2 : {22'd0, x_itm_ff.c[9:0]};
      alu    = x_itm_ff.alu_sub ? (vb - k) : (vb + k);
      rval   = alu;
      mval   = v2;
      do_reg = 1'b0;
      do_mem = 1'b0;
      pc_sum = 32'(pc_ff) + 32'd1;
      pc_in  = PC_BITS'(pc_sum);
      case (x_itm_ff.op)
         OP_ADD, OP_ADDI, OP_ADDU, OP_SUB, OP_SUBU: begin
            do_reg = 1'b1;
         end
         OP_LW: begin
            rval   = dmv;
            do_reg = 1'b1;
         end
         OP_SW: begin
            do_mem = 1'b1;
         end
         OP_BEQ: begin
            if (v2 == vb) begin
               pc_sum = 32'(pc_ff) + 32'(x_itm_ff.c) + 32'd1;
            end
            pc_in = PC_BITS'(pc_sum);
         end
         OP_J: begin
            pc_sum = 32'(pc_ff) + 32'(x_itm_ff.c);
            pc_in  = PC_BITS'(pc_sum);
         end
         OP_JR: begin
            pc_in = PC_BITS'(vb);
         end
         OP_SLT: begin
            rval   = {21'd0, x_itm_ff.c};
            do_reg = $signed({21'd0, x_itm_ff.c}) < $signed(vb);
         end
         OP_PRELOAD: begin
            mval   = x_itm_ff.pre;
            do_mem = 1'b1;
            pc_in  = pc_ff;
         end
         default: begin
            pc_in = pc_ff;
         end
      endcase
      do_reg = do_reg && x_itm_ff.a_ok;
      do_mem = do_mem && x_itm_ff.c_ok;
   end

   assign rf_we    = x_adv && do_reg;
   assign dm_we    = clr_ff || (x_adv && do_mem);
   assign dm_waddr = clr_ff ? clr_idx_ff : x_itm_ff.c[MEM_AW-1:0];
   assign dm_wdata = clr_ff ? 32'd0 : mval;

   // Read-port selection for the item being issued, with write forwarding
   always_comb begin
      ram1_in = 1'b0;
      alt1_in = 32'd0;
      if (q_itm.b_ok) begin
         if (rf_we && x_itm_ff.a == q_itm.b) begin
            alt1_in = rval;
         end else begin
            ram1_in = rf_vld_ff[q_itm.b[REG_AW-1:0]];
         end
      end
      ram2_in = 1'b0;
      alt2_in = 32'd0;
      if (q_itm.r2_ok) begin
         if (rf_we && x_itm_ff.a == q_itm.r2) begin
            alt2_in = rval;
         end else begin
            ram2_in = rf_vld_ff[q_itm.r2[REG_AW-1:0]];
         end
      end
      dram_in = 1'b0;
      dalt_in = 32'd0;
      if (q_itm.c_ok) begin
         if (x_adv && do_mem && x_itm_ff.c == q_itm.c) begin
            dalt_in = mval;
         end else begin
            dram_in = 1'b1;
         end
      end
   end

   // Register file
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[x_itm_ff.a[REG_AW-1:0]] <= rval;
      end
      if (issue) begin
         rd1_ff <= rf_mem[q_itm.b[REG_AW-1:0]];
         rd2_ff <= rf_mem[q_itm.r2[REG_AW-1:0]];
      end
   end

   // Register valid bits: an unwritten register reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_vld_ff[i] <= 1'b0;
         end
      end else if (rf_we) begin
         rf_vld_ff[x_itm_ff.a[REG_AW-1:0]] <= 1'b1;
      end
   end

   // Data memory
   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_waddr] <= dm_wdata;
      end
      if (issue) begin
         dmr_ff <= dm_mem[q_itm.c[MEM_AW-1:0]];
      end
   end

   // Clearing sweep of the data memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == MEM_AW'(MEM_WORDS - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // Execute stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (issue) begin
         x_valid_ff <= 1'b1;
      end else if (x_adv) begin
         x_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         x_itm_ff <= q_itm;
         ram1_ff  <= ram1_in;
         alt1_ff  <= alt1_in;
         ram2_ff  <= ram2_in;
         alt2_ff  <= alt2_in;
         dram_ff  <= dram_in;
         dalt_ff  <= dalt_in;
      end
   end

   // Program counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (x_adv) begin
         pc_ff <= pc_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (x_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (x_adv) begin
         next_pc_ff     <= 16'(32'(pc_in));
         reg_written_ff <= do_reg;
         reg_index_ff   <= do_reg ? x_itm_ff.a : 7'd0;
         reg_value_ff   <= do_reg ? rval : 32'd0;
         mem_written_ff <= do_mem;
         mem_address_ff <= do_mem ? x_itm_ff.c : 11'd0;
         mem_value_ff   <= do_mem ? mval : 32'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = next_pc_ff;
   assign rsp_reg_written = reg_written_ff;
   assign rsp_reg_index   = reg_index_ff;
   assign rsp_reg_value   = reg_value_ff;
   assign rsp_mem_written = mem_written_ff;
   assign rsp_mem_address = mem_address_ff;
   assign rsp_mem_value   = mem_value_ff;

endmodule

### src/toy_risc_instruction_executor_core.sv
// Executes one toy RISC instruction per item and reports the new program counter together
// with any register or data memory write it made. Items flow at one per cycle unless a
// result is held back: the front end classifies each one into a two-entry queue, the back
// end reads the register file (two ports) and data memory into the execute stage,
// then executes and writes back, with write data forwarded to the following item, so
// back-to-back dependent instructions need no stall. Items pass through the queue, the
// execute stage and the result register, which lets a new item in while a result waits.
// After reset the data memory is cleared one word per cycle while req_ready stays low.
module toy_risc_instruction_executor_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_type,
   input  logic [6:0]         req_reg_a,
   input  logic [6:0]         req_reg_b,
   input  logic [10:0]        req_c_field,
   input  logic signed [31:0] req_preload_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_next_pc,
   output logic               rsp_reg_written,
   output logic [6:0]         rsp_reg_index,
   output logic signed [31:0] rsp_reg_value,
   output logic               rsp_mem_written,
   output logic [10:0]        rsp_mem_address,
   output logic signed [31:0] rsp_mem_value
);
   import tre_pkg::*;

   itm_type     fr_itm;
   itm_type     q_itm;
   logic        fr_valid;
   logic        fr_ready;
   logic        q_valid;
   logic        q_ready;
   logic        clearing;
   logic [31:0] reg_value;
   logic [31:0] mem_value;

   // Front end: accept and classify
   tre_front u_front (
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_type   (req_type),
      .in_a      (req_reg_a),
      .in_b      (req_reg_b),
      .in_c      (req_c_field),
      .in_pre    (req_preload_value),
      .hold      (clearing),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_itm   (fr_itm)
   );

   // Decoupling queue
   tre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_itm    (fr_itm),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_itm   (q_itm)
   );

   // Back end: state, execution and result register
   tre_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_itm           (q_itm),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_reg_written (rsp_reg_written),
      .rsp_reg_index   (rsp_reg_index),
      .rsp_reg_value   (reg_value),
      .rsp_mem_written (rsp_mem_written),
      .rsp_mem_address (rsp_mem_address),
      .rsp_mem_value   (mem_value)
   );

   assign rsp_reg_value = $signed(reg_value);
   assign rsp_mem_value = $signed(mem_value);

endmodule
